>>> src/bas_pkg.sv
// shared constants, types and command/status structs of the batch admission scheduler
`timescale 1ns / 1ps
package bas_pkg;

    // table sizes
    localparam int MAX_BATCH  = 16;
    localparam int WAIT_DEPTH = 64;

    localparam int RUN_AW = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
    localparam int RC_W   = $clog2(MAX_BATCH + 1);
    localparam int WQ_AW  = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int WC_W   = $clog2(WAIT_DEPTH + 1);

    // field widths
    localparam int OP_W   = 2;
    localparam int ID_W   = 16;
    localparam int LEN_W  = 16;
    localparam int POOL_W = 17;
    localparam int TOK_W  = 17;
    localparam int KIND_W = 3;
    localparam int MBS_W  = 5;
    localparam int BS_W   = 11;
    localparam int MBT_W  = 16;
    localparam int CFG_W  = 16;
    localparam int CFG_IW = 2;

    // datapath widths
    localparam int DVD_W  = TOK_W + 1;
    localparam int DCNT_W = $clog2(DVD_W + 1);
    localparam int RES_W  = TOK_W + RC_W;
    localparam int BAT_W  = LEN_W + RC_W;

    // reset values of the configuration registers
    localparam logic [MBS_W-1:0] MBS_RST = MBS_W'(16);
    localparam logic [BS_W-1:0]  BS_RST  = BS_W'(16);
    localparam logic [MBT_W-1:0] MBT_RST = '0;

    // configuration register indexes
    localparam logic [CFG_IW-1:0] CFG_MAX_BATCH  = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_BLOCK_SIZE = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_MAX_TOKENS = 2'd2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_ADDED   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DECODE  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PREFILL = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ACK     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_EMPTY   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_FULL    = 3'd5;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_SCHED  = 2'd1,
        OP_FINISH = 2'd2,
        OP_UPDATE = 2'd3
    } op_t;

    // operand of a block count
    typedef enum logic [1:0] {
        DIV_TOTAL  = 2'd0,
        DIV_PREFIX = 2'd1,
        DIV_CACHE  = 2'd2
    } div_sel_t;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [LEN_W-1:0] plen;
        logic [LEN_W-1:0] mnew;
        logic [LEN_W-1:0] pcache;
    } req_t;

    // controller to datapath
    typedef struct packed {
        logic     accept;
        logic     fin_step;
        logic     fin_commit;
        logic     div_start;
        div_sel_t div_sel;
        logic     div_src_q;
        logic     latch_a;
        logic     latch_b;
        logic     res_acc;
        logic     fb_init;
        logic     q_rd;
        logic     q_rd_adm;
        logic     admit;
        logic     emit_dec;
        logic     emit_pre;
        logic     emit_empty;
    } bas_cmd_t;

    // datapath to controller
    typedef struct packed {
        op_t  op;
        logic out_free;
        logic check;
        logic rc_zero;
        logic idx_end;
        logic idx_last;
        logic can_admit;
        logic tok_fail;
        logic need_fail;
        logic div_done;
        logic adm_zero;
        logic adm_one;
    } bas_status_t;

endpackage

>>> src/bas_div.sv
// serial ceiling divider for block counts
`timescale 1ns / 1ps
module bas_div
    import bas_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [TOK_W-1:0] num,
    input  logic [BS_W-1:0]  den,
    output logic             done,
    output logic [TOK_W-1:0] quo
);

    logic              busy_reg;
    logic              done_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic [DVD_W-1:0]  dvd_reg;
    logic [BS_W-1:0]   rem_reg;
    logic [DVD_W-1:0]  quo_reg;
    logic [BS_W:0]     rem_sh;
    logic              fits;

    // one restoring step per cycle
    assign rem_sh = {rem_reg, dvd_reg[DVD_W-1]};
    assign fits   = (rem_sh >= {1'b0, den});

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                if (num == '0 || den == '0)
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= DCNT_W'(DVD_W);
                end
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DCNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // dividend, remainder and quotient
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= DVD_W'(num) + DVD_W'(den) - DVD_W'(1);
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
            if (fits)
            begin
                rem_reg <= BS_W'(rem_sh - {1'b0, den});
            end
            else
            begin
                rem_reg <= rem_sh[BS_W-1:0];
            end
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg[TOK_W-1:0];

endmodule

>>> src/bas_datapath.sv
// queue, running table, block accounting and result register
`timescale 1ns / 1ps
module bas_datapath
    import bas_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  bas_cmd_t          cmd,
    output bas_status_t       status,
    input  logic              cfg_we,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic [OP_W-1:0]   op,
    input  logic [LEN_W-1:0]  prompt_tokens,
    input  logic [LEN_W-1:0]  gen_limit,
    input  logic [LEN_W-1:0]  prefix_cached,
    input  logic [POOL_W-1:0] free_pool,
    input  logic [ID_W-1:0]   target_id,
    input  logic [TOK_W-1:0]  cached_tokens,
    input  logic              out_ready,
    output logic              out_valid,
    output logic [ID_W-1:0]   req_id,
    output logic [KIND_W-1:0] kind,
    output logic              last
);

    // modular add on queue positions
    function automatic logic [WQ_AW-1:0] wq_add(input logic [WQ_AW-1:0] a,
                                                input logic [WC_W-1:0]  b);
        logic [WC_W:0] s;
        s = (WC_W+1)'(a) + (WC_W+1)'(b);
        if (s >= (WC_W+1)'(WAIT_DEPTH))
        begin
            s = s - (WC_W+1)'(WAIT_DEPTH);
        end
        return s[WQ_AW-1:0];
    endfunction

    // configuration
    logic [MBS_W-1:0] mbs_reg;
    logic [BS_W-1:0]  bs_reg;
    logic [MBT_W-1:0] mbt_reg;

    // queue and running table
    req_t             wq_mem [WAIT_DEPTH];
    req_t             qrd_reg;
    req_t             run_q [MAX_BATCH];
    logic [TOK_W-1:0] run_cache [MAX_BATCH];
    logic [WQ_AW-1:0] head_reg;
    logic [WC_W-1:0]  wc_reg;
    logic [RC_W-1:0]  rc_reg;
    logic [ID_W-1:0]  nid_reg;

    // schedule working state
    logic [RC_W-1:0]   idx_reg;
    logic [RC_W-1:0]   wr_reg;
    logic [RC_W-1:0]   adm_reg;
    logic [ID_W-1:0]   tid_reg;
    logic [POOL_W-2:0] fp_reg;
    logic              check_reg;
    logic [RES_W-1:0]  res_reg;
    logic [TOK_W-1:0]  fb_reg;
    logic [BAT_W-1:0]  bat_reg;
    logic [TOK_W-1:0]  a_reg;
    logic [TOK_W-1:0]  b_reg;

    // result register
    logic              out_valid_reg;
    logic [ID_W-1:0]   rid_reg;
    logic [KIND_W-1:0] kind_reg;
    logic              last_reg;

    logic              out_free;
    req_t              ent;
    req_t              src;
    logic [TOK_W-1:0]  ent_cache;
    logic [TOK_W-1:0]  div_num;
    logic              div_done;
    logic [TOK_W-1:0]  div_q;
    logic [TOK_W-1:0]  diff_w;
    logic [TOK_W-1:0]  fut_w;
    logic [TOK_W-1:0]  need_w;
    logic [LEN_W-1:0]  eff_w;
    logic [RC_W-1:0]   cap_w;
    logic              full_w;
    logic [RES_W-1:0]  fp_ext;

    assign out_free  = !out_valid_reg || out_ready;
    assign ent       = run_q[idx_reg[RUN_AW-1:0]];
    assign ent_cache = run_cache[idx_reg[RUN_AW-1:0]];
    assign src       = cmd.div_src_q ? qrd_reg : ent;
    assign full_w    = (wc_reg == WC_W'(WAIT_DEPTH));

    // operand of the block count
    always_comb
    begin
        case (cmd.div_sel)
            DIV_TOTAL:  div_num = TOK_W'(src.plen) + TOK_W'(src.mnew);
            DIV_PREFIX: div_num = TOK_W'(src.pcache);
            DIV_CACHE:  div_num = ent_cache;
            default:    div_num = '0;
        endcase
    end

    bas_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (bs_reg),
        .done  (div_done),
        .quo   (div_q)
    );

    // reservation arithmetic
    assign diff_w = (a_reg > b_reg) ? a_reg - b_reg : '0;
    assign fut_w  = (diff_w > div_q) ? diff_w - div_q : '0;
    assign need_w = (a_reg > div_q) ? a_reg - div_q : '0;
    assign eff_w  = (qrd_reg.plen > qrd_reg.pcache) ? qrd_reg.plen - qrd_reg.pcache : '0;
    assign cap_w  = (32'(mbs_reg) > MAX_BATCH) ? RC_W'(MAX_BATCH) : RC_W'(mbs_reg);
    assign fp_ext = RES_W'(fp_reg);

    // status to the controller
    always_comb
    begin
        status.op        = op_t'(op);
        status.out_free  = out_free;
        status.check     = check_reg;
        status.rc_zero   = (rc_reg == '0);
        status.idx_end   = (idx_reg == rc_reg);
        status.idx_last  = ((RC_W+1)'(idx_reg) + (RC_W+1)'(1) == (RC_W+1)'(rc_reg));
        status.can_admit = ((RC_W+1)'(rc_reg) + (RC_W+1)'(adm_reg) < (RC_W+1)'(cap_w))
                           && (wc_reg > WC_W'(adm_reg));
        status.tok_fail  = (mbt_reg != '0) && (bat_reg != '0)
                           && ((BAT_W+1)'(bat_reg) + (BAT_W+1)'(eff_w) > (BAT_W+1)'(mbt_reg));
        status.need_fail = (need_w > fb_reg);
        status.div_done  = div_done;
        status.adm_zero  = (adm_reg == '0);
        status.adm_one   = (adm_reg == RC_W'(1));
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mbs_reg       <= MBS_RST;
            bs_reg        <= BS_RST;
            mbt_reg       <= MBT_RST;
            head_reg      <= '0;
            wc_reg        <= '0;
            rc_reg        <= '0;
            nid_reg       <= '0;
            idx_reg       <= '0;
            wr_reg        <= '0;
            adm_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // configuration writes
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_MAX_BATCH:  mbs_reg <= cfg_data[MBS_W-1:0];
                    CFG_BLOCK_SIZE: bs_reg  <= cfg_data[BS_W-1:0];
                    CFG_MAX_TOKENS: mbt_reg <= cfg_data[MBT_W-1:0];
                    default:        ;
                endcase
            end

            // result register handshake
            if (cmd.accept || cmd.emit_dec || cmd.emit_pre || cmd.emit_empty)
            begin
                out_valid_reg <= (cmd.accept) ? (op_t'(op) != OP_SCHED) : 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cmd.accept)
            begin
                idx_reg <= '0;
                wr_reg  <= '0;
                if (op_t'(op) == OP_ADD && !full_w)
                begin
                    wc_reg  <= wc_reg + 1'b1;
                    nid_reg <= nid_reg + 1'b1;
                end
            end
            if (cmd.fin_step)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (ent.id != tid_reg)
                begin
                    wr_reg <= wr_reg + 1'b1;
                end
            end
            if (cmd.fin_commit)
            begin
                rc_reg <= wr_reg;
            end
            if (cmd.res_acc || cmd.emit_dec)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.fb_init)
            begin
                idx_reg <= '0;
                adm_reg <= '0;
            end
            if (cmd.admit)
            begin
                adm_reg <= adm_reg + 1'b1;
            end
            if (cmd.emit_pre)
            begin
                adm_reg  <= adm_reg - 1'b1;
                rc_reg   <= rc_reg + 1'b1;
                wc_reg   <= wc_reg - 1'b1;
                head_reg <= wq_add(head_reg, WC_W'(1));
            end
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (cmd.accept && op_t'(op) == OP_ADD && !full_w)
        begin
            wq_mem[wq_add(head_reg, wc_reg)] <= '{id: nid_reg, plen: prompt_tokens,
                                                  mnew: gen_limit,
                                                  pcache: prefix_cached};
        end
        if (cmd.q_rd)
        begin
            qrd_reg <= wq_mem[wq_add(head_reg, cmd.q_rd_adm ? WC_W'(adm_reg) : '0)];
        end
    end

    // running table, accounting and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            tid_reg   <= target_id;
            fp_reg    <= free_pool[POOL_W-2:0];
            check_reg <= !free_pool[POOL_W-1] && (bs_reg != '0);
            res_reg   <= '0;
            last_reg  <= 1'b1;
            unique case (op_t'(op))
                OP_ADD:
                begin
                    rid_reg  <= full_w ? '0 : nid_reg;
                    kind_reg <= full_w ? KIND_FULL : KIND_ADDED;
                end
                OP_UPDATE:
                begin
                    rid_reg  <= target_id;
                    kind_reg <= KIND_ACK;
                    for (int i = 0; i < MAX_BATCH; i++)
                    begin
                        if (RC_W'(i) < rc_reg && run_q[i].id == target_id)
                        begin
                            run_cache[i] <= cached_tokens;
                        end
                    end
                end
                default:
                begin
                    rid_reg  <= target_id;
                    kind_reg <= KIND_ACK;
                end
            endcase
        end
        // compaction on finish
        if (cmd.fin_step && ent.id != tid_reg)
        begin
            run_q[wr_reg[RUN_AW-1:0]]     <= ent;
            run_cache[wr_reg[RUN_AW-1:0]] <= ent_cache;
        end
        if (cmd.latch_a)
        begin
            a_reg <= div_q;
        end
        if (cmd.latch_b)
        begin
            b_reg <= div_q;
        end
        if (cmd.res_acc)
        begin
            res_reg <= res_reg + RES_W'(fut_w);
        end
        if (cmd.fb_init)
        begin
            bat_reg <= '0;
            fb_reg  <= (check_reg && fp_ext > res_reg) ? TOK_W'(fp_ext - res_reg) : '0;
        end
        if (cmd.admit)
        begin
            bat_reg <= bat_reg + BAT_W'(eff_w);
            if (check_reg)
            begin
                fb_reg <= fb_reg - need_w;
            end
        end
        if (cmd.emit_dec)
        begin
            rid_reg  <= ent.id;
            kind_reg <= KIND_DECODE;
            last_reg <= status.idx_last && (adm_reg == '0);
        end
        if (cmd.emit_pre)
        begin
            rid_reg                        <= qrd_reg.id;
            kind_reg                       <= KIND_PREFILL;
            last_reg                       <= (adm_reg == RC_W'(1));
            run_q[rc_reg[RUN_AW-1:0]]      <= qrd_reg;
            run_cache[rc_reg[RUN_AW-1:0]]  <= '0;
        end
        if (cmd.emit_empty)
        begin
            rid_reg  <= '0;
            kind_reg <= KIND_EMPTY;
            last_reg <= 1'b1;
        end
    end

    assign out_valid  = out_valid_reg;
    assign req_id     = rid_reg;
    assign kind       = kind_reg;
    assign last       = last_reg;

endmodule

>>> src/bas_ctrl.sv
// sequencing state machine of the batch admission scheduler
`timescale 1ns / 1ps
module bas_ctrl
    import bas_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  bas_status_t status,
    output bas_cmd_t    cmd
);

    typedef enum logic [19:0] {
        ST_IDLE  = 20'h00001,
        ST_FIN   = 20'h00002,
        ST_SINIT = 20'h00004,
        ST_RA    = 20'h00008,
        ST_RAW   = 20'h00010,
        ST_RB    = 20'h00020,
        ST_RBW   = 20'h00040,
        ST_RC    = 20'h00080,
        ST_RCW   = 20'h00100,
        ST_FBI   = 20'h00200,
        ST_ADRD  = 20'h00400,
        ST_ADCK  = 20'h00800,
        ST_ADA   = 20'h01000,
        ST_ADAW  = 20'h02000,
        ST_ADB   = 20'h04000,
        ST_ADBW  = 20'h08000,
        ST_DEC   = 20'h10000,
        ST_PRRD  = 20'h20000,
        ST_PREM  = 20'h40000,
        ST_EMPTY = 20'h80000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = status.out_free;
                if (in_valid && status.out_free)
                begin
                    cmd.accept = 1'b1;
                    case (status.op)
                        OP_FINISH: state_next = ST_FIN;
                        OP_SCHED:  state_next = ST_SINIT;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_FIN:
            begin
                if (status.idx_end)
                begin
                    cmd.fin_commit = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    cmd.fin_step = 1'b1;
                end
            end
            ST_SINIT:
            begin
                state_next = (status.check && !status.rc_zero) ? ST_RA : ST_FBI;
            end
            // future reservations of running requests
            ST_RA:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_TOTAL;
                state_next    = ST_RAW;
            end
            ST_RAW:
            begin
                if (status.div_done)
                begin
                    cmd.latch_a = 1'b1;
                    state_next  = ST_RB;
                end
            end
            ST_RB:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_PREFIX;
                state_next    = ST_RBW;
            end
            ST_RBW:
            begin
                if (status.div_done)
                begin
                    cmd.latch_b = 1'b1;
                    state_next  = ST_RC;
                end
            end
            ST_RC:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_CACHE;
                state_next    = ST_RCW;
            end
            ST_RCW:
            begin
                cmd.div_sel = DIV_CACHE;
                if (status.div_done)
                begin
                    cmd.res_acc = 1'b1;
                    state_next  = status.idx_last ? ST_FBI : ST_RA;
                end
            end
            ST_FBI:
            begin
                cmd.fb_init = 1'b1;
                state_next  = ST_ADRD;
            end
            // admission decisions
            ST_ADRD:
            begin
                if (status.can_admit)
                begin
                    cmd.q_rd     = 1'b1;
                    cmd.q_rd_adm = 1'b1;
                    state_next   = ST_ADCK;
                end
                else
                begin
                    state_next = ST_DEC;
                end
            end
            ST_ADCK:
            begin
                if (status.tok_fail)
                begin
                    state_next = ST_DEC;
                end
                else if (status.check)
                begin
                    state_next = ST_ADA;
                end
                else
                begin
                    cmd.admit  = 1'b1;
                    state_next = ST_ADRD;
                end
            end
            ST_ADA:
            begin
                cmd.div_start = 1'b1;
                cmd.div_src_q = 1'b1;
                cmd.div_sel   = DIV_TOTAL;
                state_next    = ST_ADAW;
            end
            ST_ADAW:
            begin
                if (status.div_done)
                begin
                    cmd.latch_a = 1'b1;
                    state_next  = ST_ADB;
                end
            end
            ST_ADB:
            begin
                cmd.div_start = 1'b1;
                cmd.div_src_q = 1'b1;
                cmd.div_sel   = DIV_PREFIX;
                state_next    = ST_ADBW;
            end
            ST_ADBW:
            begin
                if (status.div_done)
                begin
                    if (status.need_fail)
                    begin
                        state_next = ST_DEC;
                    end
                    else
                    begin
                        cmd.admit  = 1'b1;
                        state_next = ST_ADRD;
                    end
                end
            end
            // result transfers
            ST_DEC:
            begin
                if (status.idx_end)
                begin
                    if (!status.adm_zero)
                    begin
                        state_next = ST_PRRD;
                    end
                    else
                    begin
                        state_next = status.rc_zero ? ST_EMPTY : ST_IDLE;
                    end
                end
                else if (status.out_free)
                begin
                    cmd.emit_dec = 1'b1;
                end
            end
            ST_PRRD:
            begin
                cmd.q_rd   = 1'b1;
                state_next = ST_PREM;
            end
            ST_PREM:
            begin
                if (status.out_free)
                begin
                    cmd.emit_pre = 1'b1;
                    state_next   = status.adm_one ? ST_IDLE : ST_PRRD;
                end
            end
            ST_EMPTY:
            begin
                if (status.out_free)
                begin
                    cmd.emit_empty = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> src/batch_admission_scheduler_unit.sv
// top level of the batch admission scheduler
//
// Input channel (in_valid/in_ready) carries one command per transfer: add,
// schedule, finish or update. Output channel (out_valid/out_ready) carries
// the results of that command, one per transfer, with last set on the final one.
// Configuration registers are written through cfg_we/cfg_index/cfg_data; the user
// must write them only while the block is idle, which the block itself does not
// enforce; index 0 max batch size, 1 block size, 2 token budget. Add, update and
// finish put their single result in the output register in the transfer cycle;
// finish also walks the running table to compact it. Schedule runs through the
// serial block divider (a count with a zero operand skips the divide steps):
// three counts per running request, two per admission candidate, then one decode
// result per running request and one prefill result per admitted request; with
// block accounting off no block counts are made.
// One command is in flight at a time; in_ready is high only in idle with the
// output register free or being drained.
// Reset empties the queue and the running table, clears the id counter and
// loads the register defaults. A stalled receiver holds the sequencer at the
// next result, with nothing lost.
`timescale 1ns / 1ps
module batch_admission_scheduler_unit
    import bas_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [OP_W-1:0]   op,
    input  logic [LEN_W-1:0]  prompt_tokens,
    input  logic [LEN_W-1:0]  gen_limit,
    input  logic [LEN_W-1:0]  prefix_cached,
    input  logic [POOL_W-1:0] free_pool,
    input  logic [ID_W-1:0]   target_id,
    input  logic [TOK_W-1:0]  cached_tokens,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [ID_W-1:0]   req_id,
    output logic [KIND_W-1:0] kind,
    output logic              last
);

    bas_cmd_t    cmd;
    bas_status_t status;

    // sequencer
    bas_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // storage and arithmetic
    bas_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .op             (op),
        .prompt_tokens  (prompt_tokens),
        .gen_limit      (gen_limit),
        .prefix_cached  (prefix_cached),
        .free_pool      (free_pool),
        .target_id      (target_id),
        .cached_tokens  (cached_tokens),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .req_id         (req_id),
        .kind           (kind),
        .last           (last)
    );

endmodule

>>> dv/tb_batch_admission_scheduler_unit.sv
// testbench of the batch admission scheduler: random and directed commands checked by a scoreboard
`timescale 1ns / 1ps
module tb_batch_admission_scheduler_unit;
    import bas_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    typedef struct {
        op_t                op;
        logic [LEN_W-1:0]   plen;
        logic [LEN_W-1:0]   mnew;
        logic [LEN_W-1:0]   pcache;
        logic [POOL_W-1:0]  pool;
        logic [ID_W-1:0]    tid;
        logic [TOK_W-1:0]   ctok;
    } cmd_s;

    typedef struct {
        logic [ID_W-1:0]   id;
        logic [KIND_W-1:0] knd;
        logic              lst;
    } outcome_s;

    // scheduler model plus the queue of outcomes still owed by the block
    class admission_scoreboard;
        req_t              waiting[$];
        req_t              running[$];
        int unsigned       run_cache[$];
        logic [ID_W-1:0]   next_id = '0;
        int unsigned       batch_cap = 16;
        int unsigned       blk_size = 16;
        int unsigned       tok_budget = 0;
        outcome_s          owed[$];

        function longint blocks(longint t);
            if (blk_size == 0 || t <= 0)
                return 0;
            return (t + blk_size - 1) / blk_size;
        endfunction

        function longint reservation(req_t r);
            longint v;
            v = blocks(longint'(r.plen) + longint'(r.mnew)) - blocks(longint'(r.pcache));
            return (v > 0) ? v : 0;
        endfunction

        function void set_reg(logic [CFG_IW-1:0] idx, logic [CFG_W-1:0] val);
            if (idx == CFG_MAX_BATCH)
                batch_cap = val[MBS_W-1:0];
            else if (idx == CFG_BLOCK_SIZE)
                blk_size = val[BS_W-1:0];
            else if (idx == CFG_MAX_TOKENS)
                tok_budget = val[MBT_W-1:0];
        endfunction

        function void push_outcome(logic [ID_W-1:0] id, logic [KIND_W-1:0] k, logic l);
            outcome_s o;
            o.id = id;
            o.knd = k;
            o.lst = l;
            owed.insert(owed.size(), o);
        endfunction

        // accepted command: advance the model and queue its outcomes
        function void note_command(cmd_s c);
            outcome_s batch[$];
            outcome_s o;
            req_t r;
            longint fb;
            longint f;
            longint need;
            longint batched;
            longint eff;
            bit chk;
            int unsigned cap;
            req_t keep[$];
            int unsigned keep_ct[$];
            case (c.op)
                OP_ADD:
                begin
                    if (waiting.size() >= WAIT_DEPTH)
                        push_outcome('0, KIND_FULL, 1'b1);
                    else
                    begin
                        r.id = next_id;
                        r.plen = c.plen;
                        r.mnew = c.mnew;
                        r.pcache = c.pcache;
                        waiting.insert(waiting.size(), r);
                        push_outcome(next_id, KIND_ADDED, 1'b1);
                        next_id = next_id + 1'b1;
                    end
                end
                OP_SCHED:
                begin
                    foreach (running[i])
                    begin
                        o.id = running[i].id;
                        o.knd = KIND_DECODE;
                        o.lst = 1'b0;
                        batch.insert(batch.size(), o);
                    end
                    fb = longint'($signed(c.pool));
                    chk = (fb >= 0) && (blk_size > 0);
                    if (chk)
                    begin
                        foreach (running[i])
                        begin
                            f = reservation(running[i]) - blocks(longint'(run_cache[i]));
                            if (f > 0)
                                fb -= f;
                        end
                        if (fb < 0)
                            fb = 0;
                    end
                    cap = (batch_cap > MAX_BATCH) ? MAX_BATCH : batch_cap;
                    batched = 0;
                    while (running.size() < cap && waiting.size() > 0)
                    begin
                        r = waiting[0];
                        eff = (r.plen > r.pcache) ? longint'(r.plen) - longint'(r.pcache) : 0;
                        if (tok_budget > 0 && batched > 0 && batched + eff > tok_budget)
                            break;
                        if (chk)
                        begin
                            need = reservation(r);
                            if (need > fb)
                                break;
                            fb -= need;
                        end
                        running.insert(running.size(), r);
                        run_cache.insert(run_cache.size(), 0);
                        waiting.delete(0);
                        o.id = r.id;
                        o.knd = KIND_PREFILL;
                        o.lst = 1'b0;
                        batch.insert(batch.size(), o);
                        batched += eff;
                    end
                    if (batch.size() == 0)
                    begin
                        o.id = '0;
                        o.knd = KIND_EMPTY;
                        o.lst = 1'b0;
                        batch.insert(batch.size(), o);
                    end
                    batch[batch.size()-1].lst = 1'b1;
                    foreach (batch[i])
                        owed.insert(owed.size(), batch[i]);
                end
                OP_FINISH:
                begin
                    foreach (running[i])
                        if (running[i].id != c.tid)
                        begin
                            keep.insert(keep.size(), running[i]);
                            keep_ct.insert(keep_ct.size(), run_cache[i]);
                        end
                    running = keep;
                    run_cache = keep_ct;
                    push_outcome(c.tid, KIND_ACK, 1'b1);
                end
                default:
                begin
                    foreach (running[i])
                        if (running[i].id == c.tid)
                            run_cache[i] = c.ctok;
                    push_outcome(c.tid, KIND_ACK, 1'b1);
                end
            endcase
        endfunction

        // 0 match, 1 nothing owed, 2 field mismatch
        function int check_result(logic [ID_W-1:0] id, logic [KIND_W-1:0] k, logic l,
                                  output outcome_s want);
            want = '{default: '0};
            if (owed.size() == 0)
                return 1;
            want = owed[0];
            owed.delete(0);
            if (id !== want.id || k !== want.knd || l !== want.lst)
                return 2;
            return 0;
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [CFG_IW-1:0] cfg_index = '0;
    logic [CFG_W-1:0]  cfg_data = '0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [OP_W-1:0]   op = '0;
    logic [LEN_W-1:0]  prompt_tokens = '0;
    logic [LEN_W-1:0]  gen_limit = '0;
    logic [LEN_W-1:0]  prefix_cached = '0;
    logic [POOL_W-1:0] free_pool = '0;
    logic [ID_W-1:0]   target_id = '0;
    logic [TOK_W-1:0]  cached_tokens = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [ID_W-1:0]   req_id;
    logic [KIND_W-1:0] kind;
    logic              last;

    admission_scoreboard sb = new();
    int  errors = 0;
    int  cycles = 0;
    bit  no_idle = 1'b0;

    batch_admission_scheduler_unit uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .op(op), .prompt_tokens(prompt_tokens), .gen_limit(gen_limit),
        .prefix_cached(prefix_cached), .free_pool(free_pool),
        .target_id(target_id), .cached_tokens(cached_tokens),
        .out_valid(out_valid), .out_ready(out_ready),
        .req_id(req_id), .kind(kind), .last(last)
    );

    always #10 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic report(string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    // result monitor
    always @(posedge clk)
    begin
        outcome_s want;
        int code;
        if (rst_n && out_valid && out_ready)
        begin
            code = sb.check_result(req_id, kind, last, want);
            if (code == 1)
                report($sformatf("unexpected result id=%0d kind=%0d last=%0d",
                                 req_id, kind, last));
            else if (code == 2)
                report($sformatf("got id=%0d kind=%0d last=%0d, want id=%0d kind=%0d last=%0d",
                                 req_id, kind, last, want.id, want.knd, want.lst));
        end
    end

    // receiver back-pressure
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            n = no_idle ? 0 : $urandom_range(0, 14);
            if (n > 0)
            begin
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic send_cmd(cmd_s c);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        op             <= c.op;
        prompt_tokens  <= c.plen;
        gen_limit      <= c.mnew;
        prefix_cached  <= c.pcache;
        free_pool      <= c.pool;
        target_id      <= c.tid;
        cached_tokens  <= c.ctok;
        do @(posedge clk); while (!in_ready);
        sb.note_command(c);
    endtask

    function automatic cmd_s make_cmd(op_t o, int plen, int mnew, int pc, int pool,
                                      int tid, int ct);
        cmd_s c;
        c.op = o;
        c.plen = LEN_W'(plen);
        c.mnew = LEN_W'(mnew);
        c.pcache = LEN_W'(pc);
        c.pool = POOL_W'(pool);
        c.tid = ID_W'(tid);
        c.ctok = TOK_W'(ct);
        return c;
    endfunction

    // let the block go quiet: stop commands and wait until no result is owed
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.owed.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IW-1:0] idx, int val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(val);
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_reg(idx, CFG_W'(val));
    endtask

    task automatic set_regs(int mbs, int bs, int mbt);
        drain();
        write_reg(CFG_MAX_BATCH, mbs);
        write_reg(CFG_BLOCK_SIZE, bs);
        write_reg(CFG_MAX_TOKENS, mbt);
        @(posedge clk);
    endtask

    function automatic int pick_len();
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 65535);
            1: return 0;
            default: return $urandom_range(0, 300);
        endcase
    endfunction

    // random command biased toward ids that exist
    function automatic cmd_s rand_cmd();
        cmd_s c;
        int w;
        int tid;
        w = $urandom_range(0, 99);
        c = make_cmd(OP_ADD, pick_len(), pick_len(), pick_len(), 0, 0, 0);
        if ($urandom_range(0, 3) == 0)
            c.pool = 17'h1FFFF;
        else if ($urandom_range(0, 5) == 0)
            c.pool = POOL_W'($urandom_range(0, 65535));
        else
            c.pool = POOL_W'($urandom_range(0, 200));
        tid = $urandom_range(0, 65535);
        if (sb.running.size() > 0 && $urandom_range(0, 9) < 7)
            tid = sb.running[$urandom_range(0, sb.running.size() - 1)].id;
        else if (sb.waiting.size() > 0 && $urandom_range(0, 1) == 0)
            tid = sb.waiting[$urandom_range(0, sb.waiting.size() - 1)].id;
        c.tid = ID_W'(tid);
        if ($urandom_range(0, 4) == 0)
            c.ctok = TOK_W'($urandom_range(0, 131071));
        else
            c.ctok = TOK_W'($urandom_range(0, 2000));
        if (w < 35)
            c.op = OP_ADD;
        else if (w < 60)
            c.op = OP_SCHED;
        else if (w < 85)
            c.op = OP_FINISH;
        else
            c.op = OP_UPDATE;
        return c;
    endfunction

    task automatic run_random(int count);
        repeat (count)
        begin
            if ($urandom_range(0, 29) == 0)
                no_idle = ~no_idle;
            send_cmd(rand_cmd());
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty schedule, field extremes, clamping, unknown and waiting ids
        send_cmd(make_cmd(OP_SCHED, 0, 0, 0, 17'h1FFFF, 0, 0));
        send_cmd(make_cmd(OP_ADD, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(OP_ADD, 65535, 65535, 65535, 0, 0, 0));
        send_cmd(make_cmd(OP_ADD, 100, 50, 200, 0, 0, 0));
        send_cmd(make_cmd(OP_ADD, 32, 16, 16, 0, 0, 0));
        send_cmd(make_cmd(OP_SCHED, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(OP_SCHED, 0, 0, 0, 65535, 0, 0));
        send_cmd(make_cmd(OP_UPDATE, 0, 0, 0, 0, 0, 131071));
        send_cmd(make_cmd(OP_UPDATE, 0, 0, 0, 0, 2, 17));
        send_cmd(make_cmd(OP_UPDATE, 0, 0, 0, 0, 65535, 5));
        send_cmd(make_cmd(OP_FINISH, 0, 0, 0, 0, 65535, 0));
        send_cmd(make_cmd(OP_SCHED, 0, 0, 0, 17'h1FFFF, 0, 0));
        send_cmd(make_cmd(OP_FINISH, 0, 0, 0, 0, 1, 0));
        send_cmd(make_cmd(OP_ADD, 40000, 30000, 0, 0, 0, 0));
        send_cmd(make_cmd(OP_SCHED, 0, 0, 0, 3, 0, 0));
        send_cmd(make_cmd(OP_FINISH, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(OP_SCHED, 0, 0, 0, 17'h1FFFF, 0, 0));

        // fill the waiting queue past its depth
        set_regs(1, 0, 0);
        repeat (70)
            send_cmd(make_cmd(OP_ADD, pick_len(), pick_len(), pick_len(), 0, 0, 0));
        run_random(30);

        set_regs(16, 1024, 65535);
        run_random(35);
        set_regs(5, 1, 100);
        run_random(35);
        set_regs(3, 7, 1);
        run_random(30);
        set_regs(16, 16, 0);
        run_random(40);

        drain();
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> files.f
src/bas_pkg.sv
src/bas_div.sv
src/bas_datapath.sv
src/bas_ctrl.sv
src/batch_admission_scheduler_unit.sv
dv/tb_batch_admission_scheduler_unit.sv
